// ----- design/bwf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package bwf_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DIV_W = 32;
   localparam int AXIS_LAT = 2 * DIV_W + 8;
   localparam int PIPE_DEPTH = AXIS_LAT + 1;

   localparam logic [2:0] REG_MODE = 3'd0;
   localparam logic [2:0] REG_BOX_XY = 3'd1;
   localparam logic [2:0] REG_BOX_ZW = 3'd2;
   localparam logic [2:0] REG_SCALE = 3'd3;
   localparam logic [2:0] REG_ITER_START = 3'd4;
   localparam logic [2:0] REG_ITER_STOP = 3'd5;
   localparam logic [2:0] REG_DE_SCALE = 3'd6;

   localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN = 32'h8000_0000;

   typedef struct packed {
      logic fold;
      logic wrap;
      logic sgn;
      logic floor_mode;
   } axctl_type;

   // returns {overflow, saturated value}
   function automatic logic [32:0] sat32(input logic signed [63:0] v);
      logic [32:0] r;
      begin
         if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = {1'b1, Q_MAX};
         end else if (v < -64'sh0000_0000_8000_0000) begin
            r = {1'b1, Q_MIN};
         end else begin
            r = {1'b0, v[31:0]};
         end
         return r;
      end
   endfunction

endpackage
`default_nettype wire

// ----- design/bwf_div32.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bwf_div32 (
   input  wire logic                      clock,
   input  wire logic                      en,
   input  wire logic [bwf_pkg::DIV_W-1:0] num,
   input  wire logic [bwf_pkg::DIV_W-1:0] rem_init,
   input  wire logic [bwf_pkg::DIV_W-1:0] dvs,
   output logic      [bwf_pkg::DIV_W-1:0] quo,
   output logic      [bwf_pkg::DIV_W-1:0] rem
);
   localparam int W = bwf_pkg::DIV_W;

   // restoring division, one quotient bit per stage; rem_init must be below dvs
   logic [2*W-1:0] src_w [W+1];
   logic [W-1:0]   dsrc_w [W+1];
   logic [2*W-1:0] acc_ff [W];
   logic [2*W-1:0] acc_in [W];
   logic [W-1:0]   dvs_ff [W];
   logic [W:0]     tmp_w [W];
   logic [W:0]     diff_w [W];

   assign src_w[0] = {rem_init, num};
   assign dsrc_w[0] = dvs;

   genvar k;
   for (k = 0; k < W; k++) begin : g_stage
      assign tmp_w[k] = src_w[k][2*W-1:W-1];
      assign diff_w[k] = tmp_w[k] - {1'b0, dsrc_w[k]};
      assign acc_in[k] = (tmp_w[k] >= {1'b0, dsrc_w[k]}) ?
                         {diff_w[k][W-1:0], src_w[k][W-2:0], 1'b1} :
                         {src_w[k][2*W-2:0], 1'b0};
      assign src_w[k+1] = acc_ff[k];
      assign dsrc_w[k+1] = dvs_ff[k];

      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[k] <= acc_in[k];
            dvs_ff[k] <= dsrc_w[k];
         end
      end
   end

   assign quo = acc_ff[W-1][W-1:0];
   assign rem = acc_ff[W-1][2*W-1:W];
endmodule
`default_nettype wire

// ----- design/bwf_axis.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bwf_axis (
   input  wire logic                clock,
   input  wire logic                en,
   input  wire logic signed [31:0]  orig,
   input  wire bwf_pkg::axctl_type  ctl,
   input  wire logic                scale_on,
   input  wire logic signed [31:0]  box,
   input  wire logic signed [31:0]  scale,
   output logic signed [31:0]       res,
   output logic                     ovf
);
   localparam int N = bwf_pkg::DIV_W;

   typedef struct packed {
      logic signed [31:0] orig;
      logic signed [32:0] v;
      logic signed [31:0] b;
      logic signed [33:0] t;
      logic               wrap;
      logic               scale_on;
   } sa_type;

   typedef struct packed {
      logic signed [31:0] orig;
      logic signed [32:0] v;
      logic signed [31:0] b;
      logic signed [33:0] radj;
      logic               wrap;
      logic               scale_on;
   } s1_type;

   typedef struct packed {
      logic signed [31:0] orig;
      logic signed [31:0] vs;
      logic               ovf;
      logic               scale_on;
   } s2_type;

   typedef struct packed {
      logic signed [31:0] orig;
      logic signed [31:0] vs;
      logic               ovf;
      logic               scale_on;
      logic signed [63:0] prod;
      logic [31:0]        d;
   } s3_type;

   typedef struct packed {
      logic signed [31:0] orig;
      logic signed [31:0] vs;
      logic               ovf;
      logic               scale_on;
      logic               nneg;
      logic [62:0]        nabs;
      logic [31:0]        d;
      logic               big;
   } s4_type;

   typedef struct packed {
      logic signed [31:0] orig;
      logic signed [31:0] vs;
      logic               ovf;
      logic               scale_on;
      logic               nneg;
      logic               big;
   } sb_type;

   typedef struct packed {
      logic signed [31:0] orig;
      logic signed [31:0] v;
      logic               ovf;
   } s6_type;

   sa_type a_ff, a_in;
   sa_type dla_ff [N];
   s1_type p1_ff, p1_in;
   s2_type p2_ff, p2_in;
   s3_type p3_ff, p3_in;
   s4_type p4_ff, p4_in;
   s4_type p5_ff, p5_in;
   sb_type dlb_ff [N];
   s6_type p6_ff, p6_in;
   logic signed [31:0] res_ff, res_in;
   logic ovf_ff, ovf_in;

   logic signed [32:0] orig33, mag33;
   logic signed [33:0] tneg_w, r_w;
   logic signed [34:0] w35;
   logic [32:0] sat_w;
   logic [31:0] magu, quo_a, rem_a, quo_b, rem_b, sval;
   logic [63:0] pneg;
   logic sovf;

   // stage a: fold and box offset
   always_comb begin
      orig33 = {orig[31], orig};
      mag33 = orig[31] ? -orig33 : orig33;
      a_in.orig = orig;
      a_in.v = ctl.fold ? mag33 : orig33;
      a_in.b = box;
      a_in.t = {a_in.v[32], a_in.v} + {{2{box[31]}}, box};
      a_in.wrap = ctl.wrap && !box[31] && (box != 32'sd0);
      a_in.scale_on = scale_on;
   end

   assign tneg_w = -a_ff.t;

   bwf_div32 u_div_wrap (
      .clock    (clock),
      .en       (en),
      .num      (a_ff.t[33] ? tneg_w[31:0] : a_ff.t[31:0]),
      .rem_init ('0),
      .dvs      ({a_ff.b[30:0], 1'b0}),
      .quo      (quo_a),
      .rem      (rem_a)
   );

   always_comb begin
      r_w = dla_ff[N-1].t[33] ? -{2'b00, rem_a} : {2'b00, rem_a};
      p1_in.orig = dla_ff[N-1].orig;
      p1_in.v = dla_ff[N-1].v;
      p1_in.b = dla_ff[N-1].b;
      p1_in.wrap = dla_ff[N-1].wrap;
      p1_in.scale_on = dla_ff[N-1].scale_on;
      p1_in.radj = (ctl.floor_mode && r_w[33]) ?
                   r_w + {1'b0, dla_ff[N-1].b, 1'b0} : r_w;
   end

   always_comb begin
      w35 = p1_ff.wrap ? ({p1_ff.radj[33], p1_ff.radj} - {{3{p1_ff.b[31]}}, p1_ff.b}) :
                         {{2{p1_ff.v[32]}}, p1_ff.v};
      sat_w = bwf_pkg::sat32({{29{w35[34]}}, w35});
      p2_in.orig = p1_ff.orig;
      p2_in.vs = sat_w[31:0];
      p2_in.ovf = sat_w[32];
      p2_in.scale_on = p1_ff.scale_on;
   end

   always_comb begin
      magu = p2_ff.orig[31] ? -p2_ff.orig : p2_ff.orig;
      p3_in.orig = p2_ff.orig;
      p3_in.vs = p2_ff.vs;
      p3_in.ovf = p2_ff.ovf;
      p3_in.scale_on = p2_ff.scale_on;
      p3_in.prod = p2_ff.vs * scale;
      p3_in.d = magu + (32'd1 << bwf_pkg::FRAC_BITS);
   end

   always_comb begin
      pneg = -p3_ff.prod;
      p4_in.orig = p3_ff.orig;
      p4_in.vs = p3_ff.vs;
      p4_in.ovf = p3_ff.ovf;
      p4_in.scale_on = p3_ff.scale_on;
      p4_in.nneg = p3_ff.prod[63];
      p4_in.nabs = p3_ff.prod[63] ? pneg[62:0] : p3_ff.prod[62:0];
      p4_in.d = p3_ff.d;
      p4_in.big = 1'b0;
   end

   // quotient would not fit in 32 bits
   always_comb begin
      p5_in = p4_ff;
      p5_in.big = {1'b0, p4_ff.nabs[62:32]} >= p4_ff.d;
   end

   bwf_div32 u_div_scale (
      .clock    (clock),
      .en       (en),
      .num      (p5_ff.nabs[31:0]),
      .rem_init ({1'b0, p5_ff.nabs[62:32]}),
      .dvs      (p5_ff.d),
      .quo      (quo_b),
      .rem      (rem_b)
   );

   always_comb begin
      if (!dlb_ff[N-1].nneg) begin
         sovf = dlb_ff[N-1].big || quo_b[31];
         sval = sovf ? bwf_pkg::Q_MAX : quo_b;
      end else begin
         sovf = dlb_ff[N-1].big || (quo_b > bwf_pkg::Q_MIN);
         sval = sovf ? bwf_pkg::Q_MIN : -quo_b;
      end
      p6_in.orig = dlb_ff[N-1].orig;
      p6_in.v = dlb_ff[N-1].scale_on ? sval : dlb_ff[N-1].vs;
      p6_in.ovf = dlb_ff[N-1].ovf || (dlb_ff[N-1].scale_on && sovf);
   end

   // sign restore
   always_comb begin
      res_in = p6_ff.v;
      ovf_in = p6_ff.ovf;
      if (ctl.sgn) begin
         if (p6_ff.orig[31]) begin
            if (p6_ff.v == bwf_pkg::Q_MIN) begin
               res_in = bwf_pkg::Q_MAX;
               ovf_in = 1'b1;
            end else begin
               res_in = -p6_ff.v;
            end
         end else if (p6_ff.orig == 32'sd0) begin
            res_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= a_in;
         dla_ff[0] <= a_ff;
         for (int i = 1; i < N; i++) begin
            dla_ff[i] <= dla_ff[i-1];
         end
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         p3_ff <= p3_in;
         p4_ff <= p4_in;
         p5_ff <= p5_in;
         dlb_ff[0] <= '{orig: p5_ff.orig, vs: p5_ff.vs, ovf: p5_ff.ovf,
                        scale_on: p5_ff.scale_on, nneg: p5_ff.nneg, big: p5_ff.big};
         for (int i = 1; i < N; i++) begin
            dlb_ff[i] <= dlb_ff[i-1];
         end
         p6_ff <= p6_in;
         res_ff <= res_in;
         ovf_ff <= ovf_in;
      end
   end

   assign res = res_ff;
   assign ovf = ovf_ff | (^{quo_a, rem_b} & 1'b0);
endmodule
`default_nettype wire

// ----- design/box_wrap_fold_4d.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Box wrap and fold of a 4D point plus derivative scaling.
// req_ carries one point per word; rsp_ returns one result word per point,
// in order. csr_ writes one register per handshake (index 0 mode flags,
// 1 box xy, 2 box zw, 3 scale, 4 iter start, 5 iter stop, 6 derivative
// scale); csr_ready is always high. Write registers only while idle.
// The 73 register stages are two 32-stage restoring dividers per axis (box
// remainder, then inverse magnitude scaling) plus the fold, multiply and
// saturation stages around them. Throughput: one word per cycle while
// rsp_tready does not stall the output.
// A stall on rsp_tready freezes the whole pipeline and drops req_tready in
// the same cycle; nothing is lost or repeated. Reset clears all valid bits
// and loads the register defaults; no clearing pass is needed.
module box_wrap_fold_4d (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // coord_x, coord_y, coord_z, coord_w, iteration, deriv_in
   input  wire logic [175:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // out_x, out_y, out_z, out_w, deriv_out, overflow, 7 zero bits
   output logic      [167:0] rsp_tdata,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [63:0]  csr_data
);
   localparam int DEPTH = bwf_pkg::PIPE_DEPTH;
   localparam int DL = bwf_pkg::AXIS_LAT - 1;
   localparam logic [31:0] ONE = 32'd1 << bwf_pkg::FRAC_BITS;

   logic [13:0] mode_ff;
   logic [63:0] box_xy_ff, box_zw_ff;
   logic signed [31:0] scale_ff, de_scale_ff;
   logic [15:0] iter_start_ff, iter_stop_ff;

   logic [DEPTH-1:0] vld_ff, vld_in;
   logic [175:0] in_ff;
   logic en, scale_on;
   logic signed [31:0] box_w [4];
   logic signed [31:0] res_w [4];
   logic [3:0] ovf_w;
   logic signed [63:0] dprod_ff;
   logic signed [63:0] dsh;
   logic [32:0] dl_ff [DL];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 14'd240;
         box_xy_ff <= {ONE, ONE};
         box_zw_ff <= {ONE, ONE};
         scale_ff <= ONE;
         iter_start_ff <= 16'd0;
         iter_stop_ff <= 16'd1;
         de_scale_ff <= ONE;
      end else if (csr_valid) begin
         case (csr_index)
            bwf_pkg::REG_MODE: begin
               mode_ff <= csr_data[13:0];
            end
            bwf_pkg::REG_BOX_XY: begin
               box_xy_ff <= csr_data;
            end
            bwf_pkg::REG_BOX_ZW: begin
               box_zw_ff <= csr_data;
            end
            bwf_pkg::REG_SCALE: begin
               scale_ff <= csr_data[31:0];
            end
            bwf_pkg::REG_ITER_START: begin
               iter_start_ff <= csr_data[15:0];
            end
            bwf_pkg::REG_ITER_STOP: begin
               iter_stop_ff <= csr_data[15:0];
            end
            bwf_pkg::REG_DE_SCALE: begin
               de_scale_ff <= csr_data[31:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign en = !vld_ff[DEPTH-1] || rsp_tready;
   assign req_tready = en;
   assign vld_in = {vld_ff[DEPTH-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   assign scale_on = mode_ff[13] && (in_ff[143:128] >= iter_start_ff) &&
                     (in_ff[143:128] < iter_stop_ff);

   assign box_w[0] = box_xy_ff[31:0];
   assign box_w[1] = box_xy_ff[63:32];
   assign box_w[2] = box_zw_ff[31:0];
   assign box_w[3] = box_zw_ff[63:32];

   genvar a;
   for (a = 0; a < 4; a++) begin : g_axis
      bwf_axis u_axis (
         .clock    (clock),
         .en       (en),
         .orig     (in_ff[32*a +: 32]),
         .ctl      ('{fold: mode_ff[a], wrap: mode_ff[4+a], sgn: mode_ff[8+a],
                      floor_mode: mode_ff[12]}),
         .scale_on (scale_on),
         .box      (box_w[a]),
         .scale    (scale_ff),
         .res      (res_w[a]),
         .ovf      (ovf_w[a])
      );
   end

   assign dsh = dprod_ff >>> bwf_pkg::FRAC_BITS;

   always_ff @(posedge clock) begin
      if (en) begin
         in_ff <= req_tdata;
         dprod_ff <= $signed(in_ff[175:144]) * de_scale_ff;
         dl_ff[0] <= bwf_pkg::sat32(dsh);
         for (int i = 1; i < DL; i++) begin
            dl_ff[i] <= dl_ff[i-1];
         end
      end
   end

   assign rsp_tvalid = vld_ff[DEPTH-1];
   assign rsp_tdata = {7'd0, (|ovf_w) | dl_ff[DL-1][32], dl_ff[DL-1][31:0],
                       res_w[3], res_w[2], res_w[1], res_w[0]};
endmodule
`default_nettype wire
